@@ src/assert_macros.svh @@
// shared assertion shorthands, sampled on clk and switched off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/nlc_pkg.sv @@
package nlc_pkg;

  typedef enum logic [2:0] {
    PH_START     = 3'd0,
    PH_MANT      = 3'd1,
    PH_FRAC      = 3'd2,
    PH_EXP_START = 3'd3,
    PH_EXP_SIGN  = 3'd4,
    PH_EXP_DIGIT = 3'd5,
    PH_FAIL      = 3'd6
  } phase_t;

  typedef struct packed {
    phase_t phase;
    logic   mant_seen;  // a digit before any exponent
    logic   int_ok;     // nothing so far breaks the integer form
  } nlc_state_t;

  localparam nlc_state_t STATE_CLEAR = '{phase: PH_START, mant_seen: 1'b0, int_ok: 1'b1};

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UPE   = 8'h45;
  localparam logic [7:0] CH_LOWE  = 8'h65;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

endpackage

@@ src/numeric_literal_classifier_unit.sv @@
// channel | direction | tdata                        | tuser    | tlast
// in_     | slave     | [7:0] char_code              | has_char | is_last
// out_    | master    | [0] number_ok, [1] integer_ok | -        | -
//
// one word accepted per cycle, back to back, unless held; a token's verdict
// reaches out_ through the input register, then the result register
// rst_n is synchronous, active low; it empties both stages and restarts the scan
// a stalled out_ holds the verdict; the input stage keeps moving while the word
// it holds ends no token or the result register is free or being emptied
`include "assert_macros.svh"

module numeric_literal_classifier_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_code
  input  logic       in_tuser,   // [0] has_char
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] number_ok, [1] integer_ok, [7:2] zero
);
  import nlc_pkg::*;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_has_r;
  logic       s1_last_r;

  // scanner state
  nlc_state_t state_r;
  nlc_state_t state_nxt;

  // result register
  logic       out_valid_r;
  logic       out_num_r;
  logic       out_int_r;

  logic       step_num;
  logic       step_int;
  logic       out_free;
  logic       s1_adv;
  logic       in_take;

  nlc_step u_step (
    .state_i      (state_r),
    .char_i       (s1_char_r),
    .has_i        (s1_has_r),
    .last_i       (s1_last_r),
    .state_nxt_o  (state_nxt),
    .number_ok_o  (step_num),
    .integer_ok_o (step_int)
  );

  // the held word only waits when it closes a token and the result slot is full and stalled
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_take   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_char_r <= in_tdata;
      s1_has_r  <= in_tuser;
      s1_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_CLEAR;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_num_r <= step_num;
      out_int_r <= step_int;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_int_r, out_num_r};

  // a closing word always lands a verdict in the result register
  `CHK_NEXT(a_verdict_lands, s1_adv && s1_last_r, out_valid_r, "verdict not registered")
  // the scanner restarts after each token
  `CHK_NEXT(a_scan_restarts, s1_adv && s1_last_r,
            state_r.phase == PH_START && !state_r.mant_seen && state_r.int_ok,
            "scanner not cleared after token")
  // a pending verdict is never overwritten
  `CHK_NOW(a_no_overwrite, s1_valid_r && s1_last_r && out_valid_r && !out_tready, !s1_adv,
           "verdict overwritten")
  // an integer is always a number
  `CHK_NOW(a_int_is_num, out_valid_r && out_int_r, out_num_r, "integer without number")

endmodule

@@ src/nlc_step.sv @@
module nlc_step (
  input  nlc_pkg::nlc_state_t state_i,
  input  logic [7:0]          char_i,
  input  logic                has_i,
  input  logic                last_i,
  output nlc_pkg::nlc_state_t state_nxt_o,
  output logic                number_ok_o,
  output logic                integer_ok_o
);
  import nlc_pkg::*;

  logic       digit;
  logic       sgn;
  logic       dot;
  logic       expo;
  nlc_state_t scanned;

  assign digit = (char_i >= CH_ZERO) && (char_i <= CH_NINE);
  assign sgn   = (char_i == CH_PLUS) || (char_i == CH_MINUS);
  assign dot   = (char_i == CH_DOT);
  assign expo  = (char_i == CH_UPE) || (char_i == CH_LOWE);

  // next state: fold in one character, then clear at the end of a token
  always_comb begin
    scanned = state_i;
    if (has_i) begin
      if (!digit && !(sgn && state_i.phase == PH_START)) begin
        scanned.int_ok = 1'b0;
      end
      scanned.phase = PH_FAIL;
      case (state_i.phase)
        PH_START, PH_MANT: begin
          if (digit) begin
            scanned.mant_seen = 1'b1;
            scanned.phase     = PH_MANT;
          end else if (sgn && state_i.phase == PH_START) begin
            scanned.phase = PH_MANT;
          end else if (dot) begin
            scanned.phase = PH_FRAC;
          end else if (expo && state_i.mant_seen) begin
            scanned.phase = PH_EXP_START;
          end
        end
        PH_FRAC: begin
          if (digit) begin
            scanned.mant_seen = 1'b1;
            scanned.phase     = PH_FRAC;
          end else if (expo && state_i.mant_seen) begin
            scanned.phase = PH_EXP_START;
          end
        end
        PH_EXP_START: begin
          if (digit) begin
            scanned.phase = PH_EXP_DIGIT;
          end else if (sgn) begin
            scanned.phase = PH_EXP_SIGN;
          end
        end
        PH_EXP_SIGN, PH_EXP_DIGIT: begin
          if (digit) begin
            scanned.phase = PH_EXP_DIGIT;
          end
        end
        default: begin
          // failed phase: digits still count for the integer form
          if (digit && scanned.int_ok) begin
            scanned.mant_seen = 1'b1;
          end
        end
      endcase
    end
    state_nxt_o = last_i ? STATE_CLEAR : scanned;
  end

  // verdict on the token as scanned so far
  always_comb begin
    number_ok_o  = (((scanned.phase == PH_MANT) || (scanned.phase == PH_FRAC))
                    && scanned.mant_seen) || (scanned.phase == PH_EXP_DIGIT);
    integer_ok_o = scanned.int_ok && scanned.mant_seen;
  end

endmodule

@@ test/numeric_literal_classifier_unit_tb.sv @@
module numeric_literal_classifier_unit_tb;
  import nlc_pkg::*;

  localparam int RANDOM_ITEMS = 525;  // counted words (characters or token ends) after the directed part
  localparam int DRAIN_CYCLES = 8;    // input and result registers, with margin

  typedef struct packed {
    logic number_ok;
    logic integer_ok;
  } verdict_t;

  typedef struct {
    logic [7:0] ch;
    bit         has;
    bit         last;
    bit         typed;  // want holds the expected verdict
    verdict_t   want;
  } drill_row_t;

  typedef logic [7:0] literal_q_t[$];

  localparam verdict_t REJECT = '{number_ok: 1'b0, integer_ok: 1'b0};
  localparam logic [7:0] MARKS [5] = '{CH_DOT, CH_UPE, CH_LOWE, CH_PLUS, CH_MINUS};

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] char_code
  logic       in_tuser;   // [0] has_char
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [0] number_ok, [1] integer_ok, [7:2] zero

  numeric_literal_classifier_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // directed tokens, one word per row
  drill_row_t drill [25] = '{
    '{8'h00,    1'b0, 1'b1, 1'b1, REJECT},  // empty token straight after reset
    '{CH_MINUS, 1'b1, 1'b0, 1'b0, REJECT},
    '{8'hA5,    1'b0, 1'b0, 1'b0, REJECT},  // word without a character: ignored
    '{CH_NINE,  1'b1, 1'b1, 1'b0, REJECT},
    '{"1",      1'b1, 1'b0, 1'b0, REJECT},  // trailing point
    '{CH_DOT,   1'b1, 1'b1, 1'b0, REJECT},
    '{CH_DOT,   1'b1, 1'b0, 1'b0, REJECT},  // leading point, closed by a blank word
    '{"5",      1'b1, 1'b0, 1'b0, REJECT},
    '{8'h5A,    1'b0, 1'b1, 1'b0, REJECT},
    '{CH_PLUS,  1'b1, 1'b0, 1'b0, REJECT},  // signed mantissa and signed exponent
    '{"2",      1'b1, 1'b0, 1'b0, REJECT},
    '{CH_UPE,   1'b1, 1'b0, 1'b0, REJECT},
    '{CH_MINUS, 1'b1, 1'b0, 1'b0, REJECT},
    '{"3",      1'b1, 1'b1, 1'b0, REJECT},
    '{CH_ZERO,  1'b1, 1'b0, 1'b0, REJECT},  // lower-case exponent
    '{CH_LOWE,  1'b1, 1'b0, 1'b0, REJECT},
    '{CH_NINE,  1'b1, 1'b1, 1'b0, REJECT},
    '{CH_LOWE,  1'b1, 1'b0, 1'b0, REJECT},  // exponent with no mantissa digit
    '{"1",      1'b1, 1'b1, 1'b0, REJECT},
    '{"1",      1'b1, 1'b0, 1'b0, REJECT},  // exponent with no digits
    '{CH_UPE,   1'b1, 1'b1, 1'b0, REJECT},
    '{CH_DOT,   1'b1, 1'b0, 1'b0, REJECT},  // second point sends the scan to failed
    '{CH_DOT,   1'b1, 1'b1, 1'b0, REJECT},
    '{8'hFF,    1'b1, 1'b1, 1'b1, REJECT},  // top byte value alone
    '{8'h00,    1'b1, 1'b1, 1'b1, REJECT}   // bottom byte value alone
  };

  // predictor state: where the scan is within the current token
  phase_t   scan_at;
  logic     digit_seen;   // a digit before any exponent
  logic     int_form;     // nothing so far breaks the plain integer form

  verdict_t verdicts_due[$];
  bit       steady;       // no idling on either side while set
  int       errors;
  int       items_sent;
  int       words_sent;
  int       tokens_sent;
  int       verdicts_checked;
  int       numbers_due;
  int       integers_due;

  function automatic void scan_char(input logic [7:0] c);
    logic   is_digit;
    logic   is_sign;
    logic   is_dot;
    logic   is_exp;
    phase_t nxt;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    is_sign  = (c == CH_PLUS) || (c == CH_MINUS);
    is_dot   = (c == CH_DOT);
    is_exp   = (c == CH_UPE) || (c == CH_LOWE);
    nxt      = PH_FAIL;
    // only digits and a leading sign keep the integer form alive
    if (!is_digit && !(is_sign && scan_at == PH_START)) int_form = 1'b0;
    case (scan_at)
      PH_START, PH_MANT: begin
        if (is_digit) begin
          digit_seen = 1'b1;
          nxt = PH_MANT;
        end else if (is_sign && scan_at == PH_START) begin
          nxt = PH_MANT;
        end else if (is_dot) begin
          nxt = PH_FRAC;
        end else if (is_exp && digit_seen) begin
          nxt = PH_EXP_START;
        end
      end
      PH_FRAC: begin
        if (is_digit) begin
          digit_seen = 1'b1;
          nxt = PH_FRAC;
        end else if (is_exp && digit_seen) begin
          nxt = PH_EXP_START;
        end
      end
      PH_EXP_START: begin
        if (is_digit) nxt = PH_EXP_DIGIT;
        else if (is_sign) nxt = PH_EXP_SIGN;
      end
      PH_EXP_SIGN, PH_EXP_DIGIT: begin
        if (is_digit) nxt = PH_EXP_DIGIT;
      end
      default: begin
        // failed phase: digits still count towards the integer form
        if (is_digit && int_form) digit_seen = 1'b1;
      end
    endcase
    scan_at = nxt;
  endfunction

  function automatic verdict_t close_token();
    verdict_t v;
    v.number_ok  = ((scan_at == PH_MANT || scan_at == PH_FRAC) && digit_seen) ||
                   (scan_at == PH_EXP_DIGIT);
    v.integer_ok = int_form && digit_seen;
    scan_at    = PH_START;
    digit_seen = 1'b0;
    int_form   = 1'b1;
    return v;
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  // offers one word, waits for it to be taken, then predicts
  task automatic send_word(input logic [7:0] c, input bit has, input bit last,
                           input bit typed = 1'b0, input verdict_t want = REJECT);
    verdict_t v;
    while (!steady && $urandom_range(0, 99) < 21) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tuser  <= has;
    in_tlast  <= last;
    do @(posedge clk); while (in_tready !== 1'b1);
    words_sent++;
    if (has || last) items_sent++;
    if (has) scan_char(c);
    if (last) begin
      v = close_token();
      if (typed) v = want;
      verdicts_due = {verdicts_due, v};
      tokens_sent++;
      numbers_due  += int'(v.number_ok);
      integers_due += int'(v.integer_ok);
    end
  endtask

  function automatic logic [7:0] any_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // mostly well-formed literals with random content, some damaged, some noise
  function automatic literal_q_t make_literal();
    literal_q_t s;
    int pick;
    int n_int;
    int n_frac;
    int pos;
    bit with_dot;
    pick = $urandom_range(0, 99);
    if (pick < 3) return s;
    if (pick < 8) begin
      repeat ($urandom_range(1, 4)) s = {s, 8'($urandom_range(0, 255))};
      return s;
    end
    case ($urandom_range(0, 2))
      1: s = {s, CH_PLUS};
      2: s = {s, CH_MINUS};
      default: ;
    endcase
    with_dot = ($urandom_range(0, 2) == 0);
    n_int    = $urandom_range(0, 4);
    n_frac   = with_dot ? $urandom_range(0, 3) : 0;
    if (n_int + n_frac == 0) n_int = 1;
    repeat (n_int) s = {s, any_digit()};
    if (with_dot) begin
      s = {s, CH_DOT};
      repeat (n_frac) s = {s, any_digit()};
    end
    if ($urandom_range(0, 3) == 0) begin
      s = {s, ($urandom_range(0, 1) ? CH_UPE : CH_LOWE)};
      case ($urandom_range(0, 2))
        1: s = {s, CH_PLUS};
        2: s = {s, CH_MINUS};
        default: ;
      endcase
      repeat ($urandom_range(1, 3)) s = {s, any_digit()};
    end
    // damage about three literals in ten
    if ($urandom_range(0, 9) < 3) begin
      pos = $urandom_range(0, s.size() - 1);
      case ($urandom_range(0, 3))
        0: s[pos] = 8'($urandom_range(0, 255));
        1: s[pos] = MARKS[$urandom_range(0, 4)];
        2: s.insert($urandom_range(0, s.size()), MARKS[$urandom_range(0, 4)]);
        default: s.delete(pos);
      endcase
    end
    return s;
  endfunction

  // a token may end on its last character or on a trailing blank word
  task automatic send_token(input literal_q_t s);
    bit via_blank;
    via_blank = (s.size() == 0) || ($urandom_range(0, 7) == 0);
    foreach (s[i]) begin
      if ($urandom_range(0, 19) == 0) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_word(s[i], 1'b1, !via_blank && (i == s.size() - 1));
    end
    if (via_blank) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side back-pressure
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      out_tready <= steady || ($urandom_range(0, 99) >= 21);
    end
  end

  // verdict checker, oldest expectation first
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (verdicts_due.size() == 0) begin
        flag_error($sformatf("verdict %b with none pending", out_tdata));
      end else begin
        want = verdicts_due.pop_front();
        verdicts_checked++;
        if (out_tdata[0] !== want.number_ok)
          flag_error($sformatf("verdict %0d number_ok %b, want %b",
                               verdicts_checked, out_tdata[0], want.number_ok));
        if (out_tdata[1] !== want.integer_ok)
          flag_error($sformatf("verdict %0d integer_ok %b, want %b",
                               verdicts_checked, out_tdata[1], want.integer_ok));
        if (out_tdata[7:2] !== '0)
          flag_error($sformatf("verdict %0d padding bits %b, want zero",
                               verdicts_checked, out_tdata[7:2]));
      end
    end
  end

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= 1'b0;
    in_tlast   <= 1'b0;
    steady     = 1'b0;
    scan_at    = PH_START;
    digit_seen = 1'b0;
    int_form   = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (drill[i])
      send_word(drill[i].ch, drill[i].has, drill[i].last, drill[i].typed, drill[i].want);

    while (items_sent < $size(drill) + RANDOM_ITEMS) begin
      // a long stretch at full rate in the middle of the random part
      steady = (items_sent >= 220) && (items_sent < 340);
      send_token(make_literal());
    end
    in_tvalid <= 1'b0;
    steady = 1'b0;

    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d tokens in %0d words (%0d characters or token ends), %0d verdicts checked",
             tokens_sent, words_sent, items_sent, verdicts_checked);
    $display("expected %0d valid numbers and %0d plain integers among them",
             numbers_due, integers_due);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

endmodule

@@ numeric_literal_classifier_unit.f @@
+incdir+src
src/nlc_pkg.sv
src/nlc_step.sv
src/numeric_literal_classifier_unit.sv
test/numeric_literal_classifier_unit_tb.sv
